// File: hw/rtl/box_blur_3x3_rgb_assert.svh
// Assertion helpers shared by the blur pipeline modules.
`ifndef BOX_BLUR_3X3_RGB_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BBLUR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bblur: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BBLUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bblur: next-cycle check failed");

`endif

// File: hw/rtl/bblur_pkg.sv
package bblur_pkg;

    localparam int C_MAX_WIDTH   = 1024;
    localparam int C_COL_W       = $clog2(C_MAX_WIDTH);
    localparam int C_WID_W       = C_COL_W + 1;
    localparam int C_FW_W        = 11;
    localparam int C_HGT_W       = 16;
    // input row runs past the last frame row while padding flushes the tail
    localparam int C_ROW_W       = C_HGT_W + 1;
    localparam int C_CFG_W       = 16;
    localparam int C_CFG_IDX_W   = 1;
    localparam int C_CHAN_W      = 8;
    localparam int C_SUM_W       = 12;
    localparam int C_RCP_SHIFT   = 16;
    localparam int C_RCP_W       = C_RCP_SHIFT + 1;
    localparam int C_PROD_W      = C_SUM_W + C_RCP_W;
    localparam int C_QUEUE_DEPTH = 4;
    localparam int C_QPTR_W      = $clog2(C_QUEUE_DEPTH);
    localparam int C_WIN_SIDE    = 3;
    localparam int C_WIN_N       = C_WIN_SIDE * C_WIN_SIDE;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_FRAME_WIDTH  = C_CFG_IDX_W'(0);
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FRAME_HEIGHT = C_CFG_IDX_W'(1);

    localparam logic [C_FW_W-1:0]  C_FW_RESET = C_FW_W'(640);
    localparam logic [C_HGT_W-1:0] C_FH_RESET = C_HGT_W'(480);

    typedef struct packed {
        logic [C_CHAN_W-1:0] red;
        logic [C_CHAN_W-1:0] green;
        logic [C_CHAN_W-1:0] blue;
    } t_rgb;

    // which neighbours of the due result pixel lie inside the frame
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr;

    typedef struct packed {
        t_rgb               pix;
        logic [C_COL_W-1:0] addr;
        logic               emit;
        logic               eof;
        t_nbr               nbr;
    } t_entry;

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
    } t_pair;

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_col;

    function automatic logic [3:0] f_count(input t_nbr nbr);
        logic [1:0] nc;
        logic [1:0] nr;
        nc = 2'd1 + {1'b0, nbr.left} + {1'b0, nbr.right};
        nr = 2'd1 + {1'b0, nbr.up} + {1'b0, nbr.down};
        return {2'b00, nc} * {2'b00, nr};
    endfunction

    // ceil(2^shift / n); error term stays below 2^shift for every numerator
    function automatic logic [C_RCP_W-1:0] f_recip(input logic [3:0] n);
        logic [C_RCP_W-1:0] rcp;
        unique case (n)
            4'd2:    rcp = C_RCP_W'((2 ** C_RCP_SHIFT) / 2);
            4'd3:    rcp = C_RCP_W'((2 ** C_RCP_SHIFT + 2) / 3);
            4'd4:    rcp = C_RCP_W'((2 ** C_RCP_SHIFT) / 4);
            4'd6:    rcp = C_RCP_W'((2 ** C_RCP_SHIFT + 5) / 6);
            4'd9:    rcp = C_RCP_W'((2 ** C_RCP_SHIFT + 8) / 9);
            default: rcp = C_RCP_W'(2 ** C_RCP_SHIFT);
        endcase
        return rcp;
    endfunction

endpackage

// File: hw/rtl/bblur_if.sv
interface bblur_pix_if;
    import bblur_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_CHAN_W-1:0] pixel_red;
    logic [C_CHAN_W-1:0] pixel_green;
    logic [C_CHAN_W-1:0] pixel_blue;
    logic                is_padding;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, is_padding,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, is_padding,
                    output ready);
endinterface

interface bblur_res_if;
    import bblur_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_CHAN_W-1:0] blur_red;
    logic [C_CHAN_W-1:0] blur_green;
    logic [C_CHAN_W-1:0] blur_blue;
    logic                end_of_frame;

    modport source (output valid, blur_red, blur_green, blur_blue, end_of_frame,
                    input ready);
    modport sink   (input valid, blur_red, blur_green, blur_blue, end_of_frame,
                    output ready);
endinterface

// File: hw/rtl/box_blur_3x3_rgb.sv
// 3x3 edge-aware box blur on a raster-order RGB pixel stream.
// i_pix carries one pixel per transaction (red, green, blue, is_padding) and
// o_res one blurred pixel (blur_red/green/blue, end_of_frame). Both are
// valid/ready channels; a transaction completes when valid and ready are high.
// Each pixel becomes the rounded-half-up mean of its in-frame 3x3 neighbours
// (divisor 9, 6, 4, or fewer for one-pixel-wide or -high frames).
// Results lag the stream by frame_width+1 items: after the last pixel, send
// frame_width+1 padding transactions to flush; padding during the frame is
// dropped. end_of_frame marks the final result, after which a new frame starts.
// Throughput: one transaction per cycle sustained while o_res stays ready, set by
// the simple dual-port two-line store (one read and one write per item). The
// result an item releases passes the queue, line-store read, window sum,
// reciprocal multiply and output register on its way to o_res.
// Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) writes frame_width (index 0)
// or frame_height (index 1) and restarts the frame; write only while idle.
// Reset: frame 640x480, positions zero; the line store is not cleared, since
// a stale entry only ever lands outside the frame.
// A stalled receiver holds the output register; the pipeline and a four-entry
// queue keep absorbing pixels until the queue fills, then i_pix.ready drops.
module box_blur_3x3_rgb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bblur_pix_if.sink                         i_pix,
    bblur_res_if.source                       o_res,
    input  logic                              i_cfg_we,
    input  logic [bblur_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bblur_pkg::C_CFG_W-1:0]     i_cfg_data
);
    import bblur_pkg::*;

    // front to queue
    logic   push;
    t_entry push_entry;
    logic   full;

    // queue to back
    logic   pop;
    logic   empty;
    t_entry head_entry;

    // classify each transaction, track input and output positions
    bblur_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // decouple the front from back-end stalls
    bblur_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (head_entry)
    );

    // line store, window, sum, divide and output register
    bblur_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// File: hw/rtl/bblur_front.sv
module bblur_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bblur_pix_if.sink                           i_pix,
    input  logic                                i_cfg_we,
    input  logic [bblur_pkg::C_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bblur_pkg::C_CFG_W-1:0]       i_cfg_data,
    input  logic                                i_full,
    output logic                                o_push,
    output bblur_pkg::t_entry                   o_entry
);
    import bblur_pkg::*;

    logic [C_WID_W-1:0] r_width,   n_width;
    logic [C_HGT_W-1:0] r_height,  n_height;
    logic [C_ROW_W-1:0] r_in_row,  n_in_row;
    logic [C_COL_W-1:0] r_in_col,  n_in_col;
    logic [C_HGT_W-1:0] r_out_row, n_out_row;
    logic [C_COL_W-1:0] r_out_col, n_out_col;

    logic               accept;
    logic               in_frame;
    logic               live;
    logic               emit;
    logic               eof;
    logic [C_WID_W-1:0] in_col_inc;
    logic [C_WID_W-1:0] out_col_inc;
    logic [C_HGT_W:0]   out_row_inc;

    function automatic logic [C_WID_W-1:0] f_eff_width(input logic [C_FW_W-1:0] fw);
        logic [C_WID_W-1:0] w;
        if (fw == '0) begin
            w = C_WID_W'(1);
        end else if (32'(fw) > 32'(C_MAX_WIDTH)) begin
            w = C_WID_W'(C_MAX_WIDTH);
        end else begin
            w = C_WID_W'(fw);
        end
        return w;
    endfunction

    assign i_pix.ready = !i_full;

    always_comb begin
        accept      = i_pix.valid && i_pix.ready;
        in_frame    = r_in_row < {1'b0, r_height};
        // padding inside the frame is dropped without touching state
        live        = accept && !(i_pix.is_padding && in_frame);
        emit        = (r_in_row >= C_ROW_W'(2)) ||
                      ((r_in_row == C_ROW_W'(1)) && (r_in_col != '0));
        in_col_inc  = {1'b0, r_in_col} + C_WID_W'(1);
        out_col_inc = {1'b0, r_out_col} + C_WID_W'(1);
        out_row_inc = {1'b0, r_out_row} + (C_HGT_W + 1)'(1);
        eof         = (out_row_inc >= {1'b0, r_height}) && (out_col_inc >= r_width);

        o_push            = live;
        o_entry.pix.red   = in_frame ? i_pix.pixel_red   : '0;
        o_entry.pix.green = in_frame ? i_pix.pixel_green : '0;
        o_entry.pix.blue  = in_frame ? i_pix.pixel_blue  : '0;
        o_entry.addr      = r_in_col;
        o_entry.emit      = emit;
        o_entry.eof       = eof;
        o_entry.nbr.up    = r_out_row != '0;
        o_entry.nbr.down  = out_row_inc < {1'b0, r_height};
        o_entry.nbr.left  = r_out_col != '0;
        o_entry.nbr.right = out_col_inc < r_width;
    end

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;

        if (live) begin
            if (in_col_inc >= r_width) begin
                n_in_col = '0;
                n_in_row = r_in_row + C_ROW_W'(1);
            end else begin
                n_in_col = in_col_inc[C_COL_W-1:0];
            end
            if (emit) begin
                if (eof) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end else if (out_col_inc >= r_width) begin
                    n_out_col = '0;
                    n_out_row = out_row_inc[C_HGT_W-1:0];
                end else begin
                    n_out_col = out_col_inc[C_COL_W-1:0];
                end
            end
        end

        // a register write restarts the frame
        if (i_cfg_we) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
            unique case (i_cfg_idx)
                C_REG_FRAME_WIDTH: begin
                    n_width = f_eff_width(i_cfg_data[C_FW_W-1:0]);
                end
                C_REG_FRAME_HEIGHT: begin
                    n_height = (i_cfg_data == '0) ? C_HGT_W'(1) : i_cfg_data[C_HGT_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= f_eff_width(C_FW_RESET);
            r_height  <= C_FH_RESET;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

endmodule

// File: hw/rtl/bblur_fifo.sv
`include "box_blur_3x3_rgb_assert.svh"

module bblur_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bblur_pkg::t_entry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output bblur_pkg::t_entry o_entry
);
    import bblur_pkg::*;

    t_entry              r_mem [C_QUEUE_DEPTH];
    logic [C_QPTR_W-1:0] r_wr, n_wr;
    logic [C_QPTR_W-1:0] r_rd, n_rd;
    logic [C_QPTR_W:0]   r_count, n_count;

    assign o_full  = r_count == (C_QPTR_W + 1)'(C_QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + C_QPTR_W'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + C_QPTR_W'(1) : r_rd;
        n_count = r_count + {{C_QPTR_W{1'b0}}, i_push} - {{C_QPTR_W{1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `BBLUR_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `BBLUR_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `BBLUR_ASSERT_NOW(a_ptr_count, i_clk, i_rst_n, 1'b1, C_QPTR_W'(r_wr - r_rd) == r_count[C_QPTR_W-1:0])

endmodule

// File: hw/rtl/bblur_back.sv
`include "box_blur_3x3_rgb_assert.svh"

module bblur_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  bblur_pkg::t_entry i_entry,
    output logic              o_pop,
    bblur_res_if.source       o_res
);
    import bblur_pkg::*;

    t_pair               r_mem [C_MAX_WIDTH];
    t_pair               r_rd_data;
    t_pair               r_byp_data;
    logic                r_byp;

    logic                r_s2_v;
    t_entry              r_s2;
    t_col                r_win_l;
    t_col                r_win_c;

    logic                r_s3_v;
    logic [C_SUM_W-1:0]  r_s3_num [3];
    logic [C_RCP_W-1:0]  r_s3_rcp;
    logic                r_s3_eof;

    logic                r_s4_v;
    logic [C_PROD_W-1:0] r_s4_prod [3];
    logic                r_s4_eof;

    logic                r_out_v;
    t_rgb                r_out;
    logic                r_out_eof;

    logic                out_free;
    logic                s4_go;
    logic                s4_free;
    logic                s3_go;
    logic                s3_free;
    logic                s2_go;
    logic                s2_free;

    t_pair               cur_pair;
    t_pair               wr_pair;
    t_col                new_col;
    t_rgb                win [C_WIN_N];
    logic [2:0]          col_ok;
    logic [2:0]          row_ok;
    logic [C_WIN_N-1:0]  use_bit;
    logic [3:0]          div_n;
    logic [C_SUM_W-1:0]  sum_r;
    logic [C_SUM_W-1:0]  sum_g;
    logic [C_SUM_W-1:0]  sum_b;

    // stall chain: each stage moves when the next one is free or moving
    always_comb begin
        out_free = !r_out_v || o_res.ready;
        s4_go    = r_s4_v && out_free;
        s4_free  = !r_s4_v || out_free;
        s3_go    = r_s3_v && s4_free;
        s3_free  = !r_s3_v || s4_free;
        s2_go    = r_s2_v && (!r_s2.emit || s3_free);
        s2_free  = !r_s2_v || s2_go;
        o_pop    = !i_empty && s2_free;
    end

    // line store read happens on load; a write at the same edge is bypassed
    always_comb begin
        cur_pair    = r_byp ? r_byp_data : r_rd_data;
        wr_pair.top = cur_pair.mid;
        wr_pair.mid = r_s2.pix;
        new_col.top = cur_pair.top;
        new_col.mid = cur_pair.mid;
        new_col.bot = r_s2.pix;
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_mem[r_s2.addr] <= wr_pair;
        end
        if (o_pop) begin
            r_rd_data  <= r_mem[i_entry.addr];
            r_byp_data <= wr_pair;
        end
    end

    always_comb begin
        win[0] = r_win_l.top;
        win[1] = r_win_l.mid;
        win[2] = r_win_l.bot;
        win[3] = r_win_c.top;
        win[4] = r_win_c.mid;
        win[5] = r_win_c.bot;
        win[6] = new_col.top;
        win[7] = new_col.mid;
        win[8] = new_col.bot;

        col_ok = {r_s2.nbr.right, 1'b1, r_s2.nbr.left};
        row_ok = {r_s2.nbr.down, 1'b1, r_s2.nbr.up};
        for (int c = 0; c < C_WIN_SIDE; c++) begin
            for (int r = 0; r < C_WIN_SIDE; r++) begin
                use_bit[c * C_WIN_SIDE + r] = col_ok[c] && row_ok[r];
            end
        end

        div_n = f_count(r_s2.nbr);
        // start from n/2 for round-half-up
        sum_r = C_SUM_W'(div_n[3:1]);
        sum_g = C_SUM_W'(div_n[3:1]);
        sum_b = C_SUM_W'(div_n[3:1]);
        for (int i = 0; i < C_WIN_N; i++) begin
            if (use_bit[i]) begin
                sum_r = sum_r + C_SUM_W'(win[i].red);
                sum_g = sum_g + C_SUM_W'(win[i].green);
                sum_b = sum_b + C_SUM_W'(win[i].blue);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_byp   <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_v <= o_pop;
            end
            if (o_pop) begin
                r_byp <= s2_go && (r_s2.addr == i_entry.addr);
            end
            if (s3_free) begin
                r_s3_v <= s2_go && r_s2.emit;
            end
            if (s4_free) begin
                r_s4_v <= r_s3_v;
            end
            if (out_free) begin
                r_out_v <= r_s4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2 <= i_entry;
        end
        // advance the window on every item, emitting or not
        if (s2_go) begin
            r_win_l <= r_win_c;
            r_win_c <= new_col;
        end
        if (s2_go && r_s2.emit) begin
            r_s3_num[0] <= sum_r;
            r_s3_num[1] <= sum_g;
            r_s3_num[2] <= sum_b;
            r_s3_rcp    <= f_recip(div_n);
            r_s3_eof    <= r_s2.eof;
        end
        if (s3_go) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_s4_prod[ch] <= C_PROD_W'(r_s3_num[ch]) * C_PROD_W'(r_s3_rcp);
            end
            r_s4_eof <= r_s3_eof;
        end
        if (s4_go) begin
            r_out.red   <= r_s4_prod[0][C_RCP_SHIFT +: C_CHAN_W];
            r_out.green <= r_s4_prod[1][C_RCP_SHIFT +: C_CHAN_W];
            r_out.blue  <= r_s4_prod[2][C_RCP_SHIFT +: C_CHAN_W];
            r_out_eof   <= r_s4_eof;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.blur_red     = r_out.red;
    assign o_res.blur_green   = r_out.green;
    assign o_res.blur_blue    = r_out.blue;
    assign o_res.end_of_frame = r_out_eof;

    `BBLUR_ASSERT_NOW(a_divisor_legal, i_clk, i_rst_n, r_s2_v && r_s2.emit, (div_n == 4'd1) || (div_n == 4'd2) || (div_n == 4'd3) || (div_n == 4'd4) || (div_n == 4'd6) || (div_n == 4'd9))
    `BBLUR_ASSERT_NOW(a_mean_fits, i_clk, i_rst_n, r_s4_v, (r_s4_prod[0][C_PROD_W-1:C_RCP_SHIFT+C_CHAN_W] == '0) && (r_s4_prod[1][C_PROD_W-1:C_RCP_SHIFT+C_CHAN_W] == '0) && (r_s4_prod[2][C_PROD_W-1:C_RCP_SHIFT+C_CHAN_W] == '0))
    `BBLUR_ASSERT_NEXT(a_s4_hold, i_clk, i_rst_n, r_s4_v && !out_free, r_s4_v && $stable(r_s4_eof) && $stable(r_s4_prod[0]))

endmodule

// File: tb/box_blur_3x3_rgb_checker.sv
module box_blur_3x3_rgb_checker
    import bblur_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bblur_pix_if                   i_pix,
    bblur_res_if                   i_res,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [C_CFG_W-1:0]     i_cfg_data,
    output int                     o_blur_pending,
    output int                     o_mismatches
);

    typedef struct packed {
        t_rgb rgb;
        logic eof;
    } t_blur_due;

    t_blur_due          due_blur_q[$];
    t_rgb               line_mem [0:2*C_MAX_WIDTH-1];  // older row, then newer row
    t_rgb               win [0:C_WIN_N-1];             // [slot*3 + k], k top to bottom
    int unsigned        in_row, in_col, out_row, out_col;
    logic [C_FW_W-1:0]  cfg_width;
    logic [C_HGT_W-1:0] cfg_height;
    int                 mism;

    // Rounded-half-up mean of the in-frame neighbours of (orow, ocol), centred in slot ctr.
    function automatic t_rgb neighbourhood_mean(input int ctr, input int orow, input int ocol,
                                                input int w, input int h);
        int unsigned sr, sg, sb, n;
        int          dx, dy, slot, col, row;
        t_rgb        p, m;
        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        for (dx = -1; dx <= 1; dx++) begin
            slot = ctr + dx;
            col  = ocol + dx;
            if (col >= 0 && col < w && slot >= 0 && slot <= 2) begin
                for (dy = -1; dy <= 1; dy++) begin
                    row = orow + dy;
                    if (row >= 0 && row < h) begin
                        p  = win[slot*3 + dy + 1];
                        sr += p.red;
                        sg += p.green;
                        sb += p.blue;
                        n++;
                    end
                end
            end
        end
        if (n == 0) n = 1;
        m.red   = C_CHAN_W'((sr + n/2) / n);
        m.green = C_CHAN_W'((sg + n/2) / n);
        m.blue  = C_CHAN_W'((sb + n/2) / n);
        return m;
    endfunction

    task automatic frame_restart();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endtask

    // Advance the blur state by one accepted pixel transaction; queue the result it releases.
    task automatic absorb_pixel(input logic pad, input t_rgb px);
        int unsigned w, h, c;
        logic        emit;
        t_rgb        pix, top_p, mid_p, res;
        t_blur_due   due;
        int          k;
        w = (cfg_width == 0) ? 1 : ((cfg_width > C_MAX_WIDTH) ? C_MAX_WIDTH : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        // drop padding while the frame is still arriving
        if (pad && in_row < h) return;
        pix  = (!pad && in_row < h) ? px : '0;
        c    = (in_col >= C_MAX_WIDTH) ? C_MAX_WIDTH - 1 : in_col;
        emit = (in_row >= 2) || (in_row == 1 && c >= 1);
        res  = '0;
        // at a row start the due pixel is still centred in the rightmost slot
        if (emit && c == 0) res = neighbourhood_mean(2, out_row, out_col, w, h);
        top_p = line_mem[c];
        mid_p = line_mem[C_MAX_WIDTH + c];
        for (k = 0; k < 6; k++) win[k] = win[k+3];
        win[6] = top_p;
        win[7] = mid_p;
        win[8] = pix;
        line_mem[c]               = mid_p;
        line_mem[C_MAX_WIDTH + c] = pix;
        if (emit && c >= 1) res = neighbourhood_mean(1, out_row, out_col, w, h);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (emit) begin
            due.rgb = res;
            if (out_row + 1 >= h && out_col + 1 >= w) begin
                due.eof = 1'b1;
                frame_restart();
            end else begin
                due.eof = 1'b0;
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
            due_blur_q.push_back(due);
        end
    endtask

    task automatic check_blur(input t_rgb got, input logic got_eof);
        t_blur_due due;
        if (due_blur_q.size() == 0) begin
            mism++;
            if (mism <= 10)
                $display("%0t: unexpected blur result r=%0d g=%0d b=%0d eof=%0b", $time,
                         got.red, got.green, got.blue, got_eof);
        end else begin
            due = due_blur_q.pop_front();
            if (due.rgb.red !== got.red || due.rgb.green !== got.green ||
                due.rgb.blue !== got.blue || due.eof !== got_eof) begin
                mism++;
                if (mism <= 10)
                    $display("%0t: blur mismatch: expected r=%0d g=%0d b=%0d eof=%0b, got r=%0d g=%0d b=%0d eof=%0b",
                             $time, due.rgb.red, due.rgb.green, due.rgb.blue, due.eof,
                             got.red, got.green, got.blue, got_eof);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2*C_MAX_WIDTH; i++) line_mem[i] = '0;
            for (int i = 0; i < C_WIN_N; i++) win[i] = '0;
            frame_restart();
            cfg_width  = C_FW_RESET;
            cfg_height = C_FH_RESET;
            due_blur_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == C_REG_FRAME_WIDTH) begin
                    cfg_width = i_cfg_data[C_FW_W-1:0];
                    frame_restart();
                end else if (i_cfg_idx == C_REG_FRAME_HEIGHT) begin
                    cfg_height = i_cfg_data[C_HGT_W-1:0];
                    frame_restart();
                end
            end
            if (i_res.valid && i_res.ready)
                check_blur('{i_res.blur_red, i_res.blur_green, i_res.blur_blue},
                           i_res.end_of_frame);
            if (i_pix.valid && i_pix.ready)
                absorb_pixel(i_pix.is_padding,
                             '{i_pix.pixel_red, i_pix.pixel_green, i_pix.pixel_blue});
        end
        o_blur_pending <= due_blur_q.size();
        o_mismatches   <= mism;
    end

endmodule

// File: tb/tb_box_blur_3x3_rgb.sv
// Stimulus and verdict for the 3x3 box blur. The checker beside the block
// predicts every blurred pixel and counts mismatches; this module only drives
// the pixel stream, the result back-pressure, reset and the frame registers.
module tb_box_blur_3x3_rgb;
    import bblur_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    // watchdog limit, with ample margin over the slowest legal run
    localparam int CYCLE_LIMIT  = 600000;
    // idle edges after the last predicted result, for the pipeline to settle
    localparam int DRAIN_CYCLES = 12;
    // long enough to fill the four-entry queue and the pipeline behind it
    localparam int HOLD_CYCLES  = 100;
    // pixel and flush transactions over the whole run, directed ones included
    localparam int ITEM_BUDGET  = 1400;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_CHECKER} t_fill;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx;
    logic [C_CFG_W-1:0]     i_cfg_data;

    int mismatches;
    int blur_pending;
    int cycles = 0;
    int items_sent = 0;

    // idle/stall switches for the sender and receiver processes
    bit src_jitter   = 1'b1;
    bit snk_jitter   = 1'b1;
    bit snk_hold_req = 1'b0;

    bblur_pix_if pix_ch ();
    bblur_res_if res_ch ();

    box_blur_3x3_rgb i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    box_blur_3x3_rgb_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (pix_ch),
        .i_res          (res_ch),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_blur_pending (blur_pending),
        .o_mismatches   (mismatches)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog: abandon the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** box_blur_3x3_rgb: FAILED **");
            $finish;
        end
    end

    // Result receiver: draw a stall before each transaction, or honour a
    // requested long hold-off, counted here and not by the sender.
    initial begin : result_sink
        int gap;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = snk_jitter ? $urandom_range(0, 4) : 0;
            if (snk_hold_req) begin
                gap          = HOLD_CYCLES;
                snk_hold_req = 1'b0;
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    function automatic t_rgb rand_rgb();
        t_rgb p;
        p.red   = C_CHAN_W'($urandom);
        p.green = C_CHAN_W'($urandom);
        p.blue  = C_CHAN_W'($urandom);
        return p;
    endfunction

    // Offer one pixel transaction, after a random gap when src_jitter is set; return on the edge that takes it.
    // Valid stays high afterwards so a following item goes out back to back.
    task automatic send_item(input logic pad, input t_rgb px);
        int gap;
        gap = src_jitter ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_red   <= px.red;
        pix_ch.pixel_green <= px.green;
        pix_ch.pixel_blue  <= px.blue;
        pix_ch.is_padding  <= pad;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline settle.
    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (blur_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the trailing idle edge keeps back-to-back writes apart.
    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input logic [C_CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program both dimensions; the width's unused upper bits carry noise.
    task automatic set_frame(input int w, input int h);
        logic [C_CFG_W-1:0] d;
        d               = C_CFG_W'($urandom);
        d[C_FW_W-1:0]   = C_FW_W'(w);
        write_reg(C_REG_FRAME_WIDTH, d);
        write_reg(C_REG_FRAME_HEIGHT, C_CFG_W'(h));
    endtask

    // Send a whole frame of w x h pixels (effective sizes) and its w+1 flush ticks.
    // A noisy frame also carries stray padding among its pixels (dropped by the
    // block), real pixels among the flush ticks (treated as padding), and a few
    // trailing padding ticks after end of frame (dropped as well).
    task automatic send_frame(input int w, input int h, input t_fill fill, input bit noisy);
        int   n_pix;
        int   i;
        t_rgb p;
        n_pix = w * h;
        for (i = 0; i < n_pix; i++) begin
            if (noisy && (i == n_pix/2 || $urandom_range(0, 9) == 0))
                send_item(1'b1, rand_rgb());
            case (fill)
                FILL_ZERO:    p = '0;
                FILL_FULL:    p = '1;
                FILL_CHECKER: begin
                    p.red   = i[0] ? 8'hFF : 8'h00;
                    p.green = ~p.red;
                    p.blue  = i[0] ? 8'h01 : 8'hFE;
                end
                default:      p = rand_rgb();
            endcase
            send_item(1'b0, p);
            items_sent++;
        end
        for (i = 0; i <= w; i++) begin
            if (noisy && (i == 0 || $urandom_range(0, 3) == 0))
                send_item(1'b0, rand_rgb());
            else
                send_item(1'b1, rand_rgb());
            items_sent++;
        end
        if (noisy) repeat ($urandom_range(0, 2)) send_item(1'b1, rand_rgb());
    endtask

    initial begin : stimulus
        int    w, h, wr, hr, cur_w, n;
        bit    need_cfg;
        t_fill fill;

        // hold every input at a known level from the first instant
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_red   <= '0;
        pix_ch.pixel_green <= '0;
        pix_ch.pixel_blue  <= '0;
        pix_ch.is_padding  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 3x2 checkerboard (red and green full or empty, blue near either), with stray
        // padding inside the frame and a pixel among the flush ticks.
        set_frame(3, 2);
        send_frame(3, 2, FILL_CHECKER, 1'b1);
        wait_drained();

        // Directed: zero width and height both act as one pixel.
        set_frame(0, 0);
        send_frame(1, 1, FILL_FULL, 1'b1);
        wait_drained();

        // Directed: one-pixel-wide column, two frames back to back across end of frame.
        set_frame(1, 3);
        send_frame(1, 3, FILL_ZERO, 1'b0);
        send_frame(1, 3, FILL_RANDOM, 1'b0);
        wait_drained();

        // Tallest frame, never finished: hold the receiver off while pixels
        // keep coming so the input stalls, pause the sender until all results
        // are in, resume the pixels, then abandon the frame with a register write.
        set_frame(4, 65535);
        for (n = 0; n < 30; n++) begin
            send_item(1'b0, rand_rgb());
            items_sent++;
        end
        snk_hold_req = 1'b1;
        src_jitter   = 1'b0;
        for (n = 0; n < 40; n++) begin
            send_item(1'b0, rand_rgb());
            items_sent++;
        end
        src_jitter = 1'b1;
        wait_drained();
        for (n = 0; n < 20; n++) begin
            send_item(1'b0, rand_rgb());
            items_sent++;
        end
        wait_drained();

        // Width register at its top value clamps to the widest row: one full
        // row and the start of the next at full rate, no idling on either
        // side, then abandon the frame with a register write.
        src_jitter = 1'b0;
        snk_jitter = 1'b0;
        set_frame(2**C_FW_W - 1, 2);
        for (n = 0; n < C_MAX_WIDTH + 8; n++) begin
            send_item(1'b0, rand_rgb());
            items_sent++;
        end
        wait_drained();
        src_jitter = 1'b1;
        snk_jitter = 1'b1;

        // Random frames until the item budget is spent: mostly small and well
        // formed, some noisy, some cut short.
        cur_w      = C_MAX_WIDTH;
        need_cfg   = 1'b1;
        w          = 1;
        h          = 1;
        while (items_sent < ITEM_BUDGET) begin
            src_jitter = ($urandom_range(0, 3) != 0);
            snk_jitter = ($urandom_range(0, 3) != 0);
            if (need_cfg || $urandom_range(0, 2) != 0) begin
                wait_drained();
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                case ($urandom_range(0, 9))
                    0:       w = $urandom_range(9, 40);
                    1:       h = $urandom_range(7, 12);
                    default: ;
                endcase
                wr = (w == 1 && $urandom_range(0, 1) == 0) ? 0 : w;
                hr = (h == 1 && $urandom_range(0, 1) == 0) ? 0 : h;
                if (cur_w <= 40 && $urandom_range(0, 4) == 0) begin
                    w = cur_w;
                    write_reg(C_REG_FRAME_HEIGHT, C_CFG_W'(hr));
                end else begin
                    set_frame(wr, hr);
                end
                cur_w    = w;
                need_cfg = 1'b0;
            end
            if ($urandom_range(0, 7) == 0) begin
                // cut the frame short; the next pass rewrites a register to restart
                n = $urandom_range(1, w * h);
                repeat (n) send_item(1'b0, rand_rgb());
                items_sent += n;
                need_cfg = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       fill = FILL_FULL;
                    1:       fill = FILL_ZERO;
                    2:       fill = FILL_CHECKER;
                    default: fill = FILL_RANDOM;
                endcase
                send_frame(w, h, fill, $urandom_range(0, 2) == 0);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("** box_blur_3x3_rgb: PASSED **");
        end else begin
            $display("** box_blur_3x3_rgb: FAILED **");
        end
        $finish;
    end

endmodule
